FILE: src/obrb_pkg.sv
package obrb_pkg;

  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_POP   = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_ERASE = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

endpackage

FILE: src/overwriting_byte_ring_buffer.sv
// Overwriting byte ring buffer.
//
// Command channel: drive opcode, data_byte and amount with start high. The
// word is taken at the rising edge where start is high and busy is low. busy
// follows rst and cfg_write, so outside those one word is taken every cycle.
// Opcodes are write, pop, peek, erase and clear. A write into a full buffer
// drops the oldest byte first and reports it on dropped_oldest.
//
// Result channel: one result word per command, shown for one cycle with done
// high, in the cycle right after the command was taken. Throughput is one
// word per cycle while busy is low: pointers, memory access and status
// settle in the accepting cycle, and the registered read port delivers
// read_byte in the next. The receiver cannot stall; nothing holds a result.
//
// Configuration: cfg_write with cfg_data sets the capacity in use (0 acts as
// 1, values above the depth act as the depth) and empties the buffer.
// Reset (synchronous, active high): empties the buffer, capacity goes to the
// full depth, no result pending. Storage contents are not cleared.
module overwriting_byte_ring_buffer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               opcode,
  input  logic [7:0]               data_byte,
  input  logic [obrb_pkg::CNT_W-1:0] amount,
  input  logic                     cfg_write,
  input  logic [obrb_pkg::CNT_W-1:0] cfg_data,
  output logic                     done,
  output logic [7:0]               read_byte,
  output logic                     status,
  output logic                     dropped_oldest,
  output logic [obrb_pkg::CNT_W-1:0] used_count,
  output logic [obrb_pkg::CNT_W-1:0] free_count,
  output logic [obrb_pkg::CNT_W-1:0] linear_readable,
  output logic [obrb_pkg::CNT_W-1:0] linear_writable
);
  import obrb_pkg::*;

  // Advance a position by n slots around a ring of c slots.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] pos,
                                                input logic [CNT_W-1:0] n,
                                                input logic [CNT_W-1:0] c);
    logic [CNT_W:0] s;
    begin
      s = {2'b00, pos} + {1'b0, n};
      if (s >= {1'b0, c}) s = s - {1'b0, c};
      if (s >= {1'b0, c}) s = '0;
      return s[PTR_W-1:0];
    end
  endfunction

  // Architectural state
  logic [CNT_W-1:0] cap;
  logic [PTR_W-1:0] rd_pos;
  logic [PTR_W-1:0] wr_pos;
  logic [CNT_W-1:0] free_slots;

  logic [CNT_W-1:0] cap_next;
  logic [PTR_W-1:0] rd_pos_next;
  logic [PTR_W-1:0] wr_pos_next;
  logic [CNT_W-1:0] free_slots_next;

  // Result register
  logic rd_valid;
  logic rd_valid_next;
  logic status_next;
  logic dropped_next;

  // Storage
  logic [7:0]       mem [DEPTH];
  logic [7:0]       mem_q;
  logic             mem_we;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;

  logic             accept;
  logic [CNT_W-1:0] used;

  // Hold off commands while a capacity write empties the buffer.
  assign busy   = rst | cfg_write;
  assign accept = start & ~busy;
  assign used   = cap - free_slots;

  // Clamp the requested capacity into 1..DEPTH.
  always_comb begin
    if (cfg_data == '0) begin
      cap_next = CNT_W'(1);
    end else if (cfg_data > CNT_W'(DEPTH)) begin
      cap_next = CNT_W'(DEPTH);
    end else begin
      cap_next = cfg_data;
    end
  end

  // Single-pass command decode: next pointers, memory access, status.
  always_comb begin
    rd_pos_next     = rd_pos;
    wr_pos_next     = wr_pos;
    free_slots_next = free_slots;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = rd_pos;
    rd_valid_next   = 1'b0;
    status_next     = 1'b0;
    dropped_next    = 1'b0;
    case (opcode)
      OP_WRITE: begin
        // Full: drop the oldest byte, the write then takes its slot back.
        if (free_slots == '0) begin
          rd_pos_next  = wrap_add(rd_pos, CNT_W'(1), cap);
          dropped_next = 1'b1;
        end else begin
          free_slots_next = free_slots - CNT_W'(1);
        end
        mem_we      = 1'b1;
        wr_pos_next = wrap_add(wr_pos, CNT_W'(1), cap);
      end
      OP_POP: begin
        if (used == '0) begin
          status_next = 1'b1;
        end else begin
          mem_re          = 1'b1;
          rd_valid_next   = 1'b1;
          rd_pos_next     = wrap_add(rd_pos, CNT_W'(1), cap);
          free_slots_next = free_slots + CNT_W'(1);
        end
      end
      OP_PEEK: begin
        mem_raddr = wrap_add(rd_pos, amount, cap);
        if (amount >= used) begin
          status_next = 1'b1;
        end else begin
          mem_re        = 1'b1;
          rd_valid_next = 1'b1;
        end
      end
      OP_ERASE: begin
        if (amount > used) begin
          status_next = 1'b1;
        end else begin
          rd_pos_next     = wrap_add(rd_pos, amount, cap);
          free_slots_next = free_slots + amount;
        end
      end
      OP_CLEAR: begin
        rd_pos_next     = '0;
        wr_pos_next     = '0;
        free_slots_next = cap;
      end
      default: begin
        // unused opcode: no change, plain done status
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap        <= CAP_RESET;
      rd_pos     <= '0;
      wr_pos     <= '0;
      free_slots <= CAP_RESET;
      done       <= 1'b0;
    end else if (cfg_write) begin
      // Capacity change empties the buffer.
      cap        <= cap_next;
      rd_pos     <= '0;
      wr_pos     <= '0;
      free_slots <= cap_next;
      done       <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        rd_pos     <= rd_pos_next;
        wr_pos     <= wr_pos_next;
        free_slots <= free_slots_next;
      end
    end
  end

  // Payload of the result word; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_valid       <= rd_valid_next;
      status         <= status_next;
      dropped_oldest <= dropped_next;
    end
  end

  // Byte storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      mem[wr_pos] <= data_byte;
    end
    if (accept && mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  assign read_byte = rd_valid ? mem_q : 8'h00;

  // In the done cycle the state registers hold the post-command state, so
  // the occupancy figures come straight from them.
  assign used_count = used;
  assign free_count = free_slots;

  always_comb begin
    if (rd_pos < wr_pos) begin
      linear_readable = {1'b0, wr_pos} - {1'b0, rd_pos};
    end else if (free_slots == cap) begin
      linear_readable = '0;
    end else begin
      linear_readable = cap - {1'b0, rd_pos};
    end

    if (rd_pos > wr_pos) begin
      linear_writable = {1'b0, rd_pos} - {1'b0, wr_pos};
    end else if (free_slots == '0) begin
      linear_writable = '0;
    end else begin
      linear_writable = cap - {1'b0, wr_pos};
    end
  end

endmodule

FILE: src/obrb_checker.sv
module obrb_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [2:0]               opcode,
  input logic                     cfg_write,
  input logic                     done,
  input logic [7:0]               read_byte,
  input logic                     status,
  input logic                     dropped_oldest,
  input logic [obrb_pkg::CNT_W-1:0] used_count,
  input logic [obrb_pkg::CNT_W-1:0] free_count,
  input logic [obrb_pkg::CNT_W-1:0] linear_readable,
  input logic [obrb_pkg::CNT_W-1:0] linear_writable
);
  import obrb_pkg::*;

  // One result word in the cycle after each accepted command word.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cfg_write) |=> done)
    else $error("accepted word produced no result");

  // Used plus free never exceeds the storage depth.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, used_count} + {1'b0, free_count}) <= (CNT_W + 1)'(DEPTH))
    else $error("used plus free exceeds depth");

  // A drop only happens on a successful write into a full buffer.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (done && dropped_oldest) |-> (free_count == '0 && !status))
    else $error("drop reported without full buffer");

  // Rejected requests return no data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (read_byte == 8'h00))
    else $error("error result carries data");

  // Clear leaves an empty buffer with full free runs.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cfg_write && opcode == OP_CLEAR) |=>
      (used_count == '0 && linear_readable == '0 && linear_writable == free_count))
    else $error("clear did not empty buffer");

endmodule

bind overwriting_byte_ring_buffer obrb_checker u_obrb_checker (.*);
